// ===== rtl/fia_pkg.sv =====
// ----------------------------------------------------------------------------
// fia_pkg
// shared types and constants of the flow incident aggregator
// ----------------------------------------------------------------------------
`default_nettype none

package fia_pkg;

   localparam int STATUS_W     = 3;
   localparam int BUCKET_OUT_W = 10;
   localparam int DESTS_OUT_W  = 4;
   localparam int FLOWS_W      = 32;
   localparam int KEY_W        = 56;
   localparam int SUM_W        = 64;

   localparam logic [STATUS_W-1:0] ST_NEW_INCIDENT = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NEW_DEST     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DEST_KNOWN   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BUCKET_FULL  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DEST_FULL    = 3'd4;

   typedef struct packed {
      logic                load;
      logic                clear_wr;
      logic                entry_wr;
      logic                alloc;
      logic                dest_wr;
      logic                fill_inc;
      logic                emit;
      logic [STATUS_W-1:0] status;
   } fia_cmd_type;

   typedef struct packed {
      logic key_match;
      logic dest_match;
   } fia_stat_type;

endpackage

`default_nettype wire

// ===== rtl/fia_ctrl.sv =====
// ----------------------------------------------------------------------------
// fia_ctrl
// sequencer: table clear, way scan, destination scan, write back
// ----------------------------------------------------------------------------
`default_nettype none

module fia_ctrl
   import fia_pkg::*;
#(
   parameter int BUCKET_BITS     = 10,
   parameter int WAYS            = 4,
   parameter int DESTS_PER_ENTRY = 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   output fia_cmd_type                             cmd,
   input  wire fia_stat_type                       stat,
   input  wire logic [$clog2(WAYS+1)-1:0]          way_count,
   input  wire logic [$clog2(DESTS_PER_ENTRY+1)-1:0] dest_fill,
   output logic [$clog2(WAYS+1)-1:0]               way_idx,
   output logic [$clog2(DESTS_PER_ENTRY+1)-1:0]    slot_idx,
   output logic [BUCKET_BITS-1:0]                  clear_idx
);

   localparam int CW = $clog2(WAYS+1);
   localparam int FW = $clog2(DESTS_PER_ENTRY+1);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_WWAIT = 3'd2;
   localparam logic [2:0] S_WCHK  = 3'd3;
   localparam logic [2:0] S_DWAIT = 3'd4;
   localparam logic [2:0] S_DCHK  = 3'd5;

   logic [2:0]             state_ff, state_in;
   logic [CW-1:0]          way_ff, way_in;
   logic [FW-1:0]          slot_ff, slot_in;
   logic [BUCKET_BITS-1:0] clr_ff, clr_in;

   always_comb begin
      state_in = state_ff;
      way_in   = way_ff;
      slot_in  = slot_ff;
      clr_in   = clr_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            clr_in       = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               way_in   = '0;
               slot_in  = '0;
               state_in = S_WWAIT;
            end
         end
         S_WWAIT: begin
            state_in = S_WCHK;
         end
         S_WCHK: begin
            if (way_ff < way_count) begin
               if (stat.key_match) begin
                  state_in = S_DWAIT;
               end else begin
                  way_in   = way_ff + 1'b1;
                  state_in = S_WWAIT;
               end
            end else begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
               if (way_count < CW'(WAYS)) begin
                  cmd.entry_wr = 1'b1;
                  cmd.alloc    = 1'b1;
                  cmd.dest_wr  = 1'b1;
                  cmd.status   = ST_NEW_INCIDENT;
               end else begin
                  cmd.status = ST_BUCKET_FULL;
               end
            end
         end
         S_DWAIT: begin
            state_in = S_DCHK;
         end
         S_DCHK: begin
            if (slot_ff >= dest_fill) begin
               cmd.entry_wr = 1'b1;
               cmd.emit     = 1'b1;
               state_in     = S_IDLE;
               if (dest_fill >= FW'(DESTS_PER_ENTRY)) begin
                  cmd.status = ST_DEST_FULL;
               end else begin
                  cmd.dest_wr  = 1'b1;
                  cmd.fill_inc = 1'b1;
                  cmd.status   = ST_NEW_DEST;
               end
            end else if (stat.dest_match) begin
               cmd.entry_wr = 1'b1;
               cmd.emit     = 1'b1;
               cmd.status   = ST_DEST_KNOWN;
               state_in     = S_IDLE;
            end else begin
               slot_in  = slot_ff + 1'b1;
               state_in = S_DWAIT;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         way_ff   <= '0;
         slot_ff  <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         way_ff   <= way_in;
         slot_ff  <= slot_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign way_idx   = way_ff;
   assign slot_idx  = slot_ff;
   assign clear_idx = clr_ff;

endmodule

`default_nettype wire

// ===== rtl/fia_datapath.sv =====
// ----------------------------------------------------------------------------
// fia_datapath
// record registers, bucket fill memory, entry and destination memories
// ----------------------------------------------------------------------------
`default_nettype none

module fia_datapath
   import fia_pkg::*;
#(
   parameter int BUCKET_BITS     = 10,
   parameter int WAYS            = 4,
   parameter int DESTS_PER_ENTRY = 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire fia_cmd_type                          cmd,
   output fia_stat_type                              stat,
   output logic [$clog2(WAYS+1)-1:0]                 way_count,
   output logic [$clog2(DESTS_PER_ENTRY+1)-1:0]      dest_fill,
   input  wire logic [$clog2(WAYS+1)-1:0]            way_idx,
   input  wire logic [$clog2(DESTS_PER_ENTRY+1)-1:0] slot_idx,
   input  wire logic [BUCKET_BITS-1:0]               clear_idx,
   input  wire logic [31:0]                          req_source_address,
   input  wire logic [15:0]                          req_destination_port,
   input  wire logic [7:0]                           req_protocol_number,
   input  wire logic [31:0]                          req_destination_address,
   input  wire logic [31:0]                          req_packet_count,
   input  wire logic [31:0]                          req_octet_count,
   input  wire logic [31:0]                          req_start_time,
   input  wire logic [31:0]                          req_end_time,
   output logic                                      rsp_valid,
   output logic [STATUS_W-1:0]                       rsp_status,
   output logic [BUCKET_OUT_W-1:0]                   rsp_bucket_index,
   output logic [DESTS_OUT_W-1:0]                    rsp_distinct_destinations,
   output logic [FLOWS_W-1:0]                        rsp_incident_flows
);

   localparam int CW  = $clog2(WAYS+1);
   localparam int FW  = $clog2(DESTS_PER_ENTRY+1);
   localparam int AW  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int SW  = (DESTS_PER_ENTRY > 1) ? $clog2(DESTS_PER_ENTRY) : 1;
   localparam int EW  = BUCKET_BITS + AW;
   localparam int DW  = EW + SW;

   logic [31:0] src_ff, dst_ff, pkts_ff, octs_ff, tf_ff, tl_ff;
   logic [15:0] port_ff;
   logic [7:0]  proto_ff;

   logic [CW-1:0]      cnt_mem [2**BUCKET_BITS];
   logic [KEY_W-1:0]   key_mem [2**EW];
   logic [FLOWS_W-1:0] flows_mem [2**EW];
   logic [SUM_W-1:0]   pkts_mem [2**EW];
   logic [SUM_W-1:0]   octs_mem [2**EW];
   logic [31:0]        first_mem [2**EW];
   logic [31:0]        last_mem [2**EW];
   logic [FW-1:0]      fill_mem [2**EW];
   logic [31:0]        dest_mem [2**DW];

   logic [CW-1:0]      cnt_q_ff;
   logic [KEY_W-1:0]   key_q_ff;
   logic [FLOWS_W-1:0] flows_q_ff;
   logic [SUM_W-1:0]   pkts_q_ff, octs_q_ff;
   logic [31:0]        first_q_ff, last_q_ff, dest_q_ff;
   logic [FW-1:0]      fill_q_ff;

   logic [15:0]            hash;
   logic [BUCKET_BITS-1:0] bucket;
   logic [EW-1:0]          ent_addr;
   logic [DW-1:0]          dest_addr;
   logic [KEY_W-1:0]       key;
   logic [FLOWS_W-1:0]     flows_new;
   logic [SUM_W-1:0]       pkts_new, octs_new;
   logic [31:0]            first_new, last_new;
   logic [FW:0]            fill_plus;
   logic [FW-1:0]          fill_new;
   logic [DESTS_OUT_W-1:0] dests_out;
   logic [FLOWS_W-1:0]     flows_out;

   logic                   rsp_valid_ff;
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic [BUCKET_OUT_W-1:0] rsp_bucket_ff;
   logic [DESTS_OUT_W-1:0] rsp_dests_ff;
   logic [FLOWS_W-1:0]     rsp_flows_ff;

   assign hash      = src_ff[15:0] ^ src_ff[31:16] ^ port_ff;
   assign bucket    = hash[BUCKET_BITS-1:0];
   assign ent_addr  = {bucket, way_idx[AW-1:0]};
   assign dest_addr = {ent_addr, slot_idx[SW-1:0]};
   assign key       = {src_ff, port_ff, proto_ff};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         src_ff   <= req_source_address;
         port_ff  <= req_destination_port;
         proto_ff <= req_protocol_number;
         dst_ff   <= req_destination_address;
         pkts_ff  <= req_packet_count;
         octs_ff  <= req_octet_count;
         tf_ff    <= req_start_time;
         tl_ff    <= req_end_time;
      end
   end

   // bucket fill counts
   always_ff @(posedge clock) begin
      if (cmd.clear_wr) begin
         cnt_mem[clear_idx] <= '0;
      end else if (cmd.alloc) begin
         cnt_mem[bucket] <= cnt_q_ff + 1'b1;
      end
      cnt_q_ff <= cnt_mem[bucket];
   end

   assign fill_plus = {1'b0, fill_q_ff} + 1'b1;
   assign fill_new  = cmd.fill_inc ? fill_plus[FW-1:0] : fill_q_ff;
   assign flows_new = cmd.alloc ? FLOWS_W'(1) : flows_q_ff + 1'b1;
   assign pkts_new  = cmd.alloc ? SUM_W'(pkts_ff) : pkts_q_ff + SUM_W'(pkts_ff);
   assign octs_new  = cmd.alloc ? SUM_W'(octs_ff) : octs_q_ff + SUM_W'(octs_ff);
   assign first_new = (cmd.alloc || first_q_ff > tf_ff) ? tf_ff : first_q_ff;
   assign last_new  = (cmd.alloc || last_q_ff < tl_ff) ? tl_ff : last_q_ff;

   always_ff @(posedge clock) begin
      if (cmd.entry_wr) begin
         key_mem[ent_addr]   <= key;
         flows_mem[ent_addr] <= flows_new;
         pkts_mem[ent_addr]  <= pkts_new;
         octs_mem[ent_addr]  <= octs_new;
         first_mem[ent_addr] <= first_new;
         last_mem[ent_addr]  <= last_new;
         fill_mem[ent_addr]  <= cmd.alloc ? FW'(1) : fill_new;
      end
      key_q_ff   <= key_mem[ent_addr];
      flows_q_ff <= flows_mem[ent_addr];
      pkts_q_ff  <= pkts_mem[ent_addr];
      octs_q_ff  <= octs_mem[ent_addr];
      first_q_ff <= first_mem[ent_addr];
      last_q_ff  <= last_mem[ent_addr];
      fill_q_ff  <= fill_mem[ent_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.dest_wr) begin
         dest_mem[dest_addr] <= dst_ff;
      end
      dest_q_ff <= dest_mem[dest_addr];
   end

   always_comb begin
      case (cmd.status)
         ST_NEW_INCIDENT: begin
            dests_out = DESTS_OUT_W'(1);
            flows_out = FLOWS_W'(1);
         end
         ST_NEW_DEST: begin
            dests_out = DESTS_OUT_W'(fill_plus);
            flows_out = flows_q_ff + 1'b1;
         end
         ST_DEST_KNOWN, ST_DEST_FULL: begin
            dests_out = DESTS_OUT_W'(fill_q_ff);
            flows_out = flows_q_ff + 1'b1;
         end
         default: begin
            dests_out = '0;
            flows_out = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
      if (cmd.emit) begin
         rsp_status_ff <= cmd.status;
         rsp_bucket_ff <= BUCKET_OUT_W'(bucket);
         rsp_dests_ff  <= dests_out;
         rsp_flows_ff  <= flows_out;
      end
   end

   assign stat.key_match  = (key_q_ff == key);
   assign stat.dest_match = (dest_q_ff == dst_ff);
   assign way_count       = cnt_q_ff;
   assign dest_fill       = fill_q_ff;

   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_status                = rsp_status_ff;
   assign rsp_bucket_index          = rsp_bucket_ff;
   assign rsp_distinct_destinations = rsp_dests_ff;
   assign rsp_incident_flows        = rsp_flows_ff;

endmodule

`default_nettype wire

// ===== rtl/flow_incident_aggregator_core.sv =====
// ----------------------------------------------------------------------------
// flow_incident_aggregator_core
// hashed incident table that aggregates flow records by source, port, protocol
// ----------------------------------------------------------------------------
// A flow record transaction is taken when start is high and busy is low. The
// record is hashed to a bucket of WAYS entries; a matching entry has its
// counters, times and destination set updated, a miss claims the next free
// way, and a full bucket drops the record.
// One result per record appears on the rsp_ ports for a single cycle with
// rsp_valid high; the receiver cannot stall, so results are never held.
// The record is scanned one way at a time and, on a hit, one destination
// slot at a time; each step is one memory read with a registered read.
// busy stays high until the result is issued, so records are processed one
// at a time.
// After reset the bucket fill memory is cleared, one bucket per cycle, until
// every bucket is zero; busy is high during the clear.
// ----------------------------------------------------------------------------
`default_nettype none

module flow_incident_aggregator_core
   import fia_pkg::*;
#(
   parameter int BUCKET_BITS     = 10,
   parameter int WAYS            = 4,
   parameter int DESTS_PER_ENTRY = 8
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic [31:0]             req_source_address,
   input  wire logic [15:0]             req_destination_port,
   input  wire logic [7:0]              req_protocol_number,
   input  wire logic [31:0]             req_destination_address,
   input  wire logic [31:0]             req_packet_count,
   input  wire logic [31:0]             req_octet_count,
   input  wire logic [31:0]             req_start_time,
   input  wire logic [31:0]             req_end_time,
   output logic                         rsp_valid,
   output logic [STATUS_W-1:0]          rsp_status,
   output logic [BUCKET_OUT_W-1:0]      rsp_bucket_index,
   output logic [DESTS_OUT_W-1:0]       rsp_distinct_destinations,
   output logic [FLOWS_W-1:0]           rsp_incident_flows
);

   localparam int CW = $clog2(WAYS+1);
   localparam int FW = $clog2(DESTS_PER_ENTRY+1);

   fia_cmd_type            cmd;
   fia_stat_type           stat;
   logic [CW-1:0]          way_count, way_idx;
   logic [FW-1:0]          dest_fill, slot_idx;
   logic [BUCKET_BITS-1:0] clear_idx;

   fia_ctrl #(
      .BUCKET_BITS     (BUCKET_BITS),
      .WAYS            (WAYS),
      .DESTS_PER_ENTRY (DESTS_PER_ENTRY)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .cmd       (cmd),
      .stat      (stat),
      .way_count (way_count),
      .dest_fill (dest_fill),
      .way_idx   (way_idx),
      .slot_idx  (slot_idx),
      .clear_idx (clear_idx)
   );

   fia_datapath #(
      .BUCKET_BITS     (BUCKET_BITS),
      .WAYS            (WAYS),
      .DESTS_PER_ENTRY (DESTS_PER_ENTRY)
   ) u_datapath (
      .clock                     (clock),
      .reset                     (reset),
      .cmd                       (cmd),
      .stat                      (stat),
      .way_count                 (way_count),
      .dest_fill                 (dest_fill),
      .way_idx                   (way_idx),
      .slot_idx                  (slot_idx),
      .clear_idx                 (clear_idx),
      .req_source_address        (req_source_address),
      .req_destination_port      (req_destination_port),
      .req_protocol_number       (req_protocol_number),
      .req_destination_address   (req_destination_address),
      .req_packet_count          (req_packet_count),
      .req_octet_count           (req_octet_count),
      .req_start_time            (req_start_time),
      .req_end_time              (req_end_time),
      .rsp_valid                 (rsp_valid),
      .rsp_status                (rsp_status),
      .rsp_bucket_index          (rsp_bucket_index),
      .rsp_distinct_destinations (rsp_distinct_destinations),
      .rsp_incident_flows        (rsp_incident_flows)
   );

`ifndef SYNTHESIS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transaction did not raise busy");

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back to back results");

   a_drop_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_BUCKET_FULL |->
         rsp_distinct_destinations == '0 && rsp_incident_flows == '0)
      else $error("dropped record reported nonzero counts");

   a_new_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_NEW_INCIDENT |->
         rsp_distinct_destinations == DESTS_OUT_W'(1) &&
         rsp_incident_flows == FLOWS_W'(1))
      else $error("new incident reported wrong counts");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_flow_incident_aggregator_core.sv =====
// ----------------------------------------------------------------------------
// tb_flow_incident_aggregator_core
// self-checking testbench of the flow incident aggregator
// ----------------------------------------------------------------------------
// Flow records are driven from a queue with random gaps; a local incident
// table predicts status, bucket, distinct destinations and flow count of
// each record, and every rsp_valid transaction is checked against the oldest
// prediction. Stimulus concentrates records on a few buckets and keys so
// that hits, new destinations, full destination sets and full buckets occur.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_flow_incident_aggregator_core;
   import fia_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BUCKET_BITS     = 10;
   localparam int WAYS            = 4;
   localparam int DESTS_PER_ENTRY = 8;
   localparam int NUM_ENTRIES     = (1 << BUCKET_BITS) * WAYS;
   localparam int IDLE_LIMIT      = 20000;

   typedef struct packed {
      logic [31:0] src;
      logic [15:0] port;
      logic [7:0]  proto;
      logic [31:0] dst;
      logic [31:0] pkts;
      logic [31:0] octs;
      logic [31:0] t_first;
      logic [31:0] t_last;
   } flow_record_type;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic [BUCKET_OUT_W-1:0] bucket;
      logic [DESTS_OUT_W-1:0]  dests;
      logic [FLOWS_W-1:0]      flows;
   } incident_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [31:0] req_source_address = '0;
   logic [15:0] req_destination_port = '0;
   logic [7:0]  req_protocol_number = '0;
   logic [31:0] req_destination_address = '0;
   logic [31:0] req_packet_count = '0;
   logic [31:0] req_octet_count = '0;
   logic [31:0] req_start_time = '0;
   logic [31:0] req_end_time = '0;
   logic rsp_valid;
   logic [STATUS_W-1:0]     rsp_status;
   logic [BUCKET_OUT_W-1:0] rsp_bucket_index;
   logic [DESTS_OUT_W-1:0]  rsp_distinct_destinations;
   logic [FLOWS_W-1:0]      rsp_incident_flows;

   flow_incident_aggregator_core #(
      .BUCKET_BITS(BUCKET_BITS), .WAYS(WAYS), .DESTS_PER_ENTRY(DESTS_PER_ENTRY)
   ) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_source_address(req_source_address),
      .req_destination_port(req_destination_port),
      .req_protocol_number(req_protocol_number),
      .req_destination_address(req_destination_address),
      .req_packet_count(req_packet_count),
      .req_octet_count(req_octet_count),
      .req_start_time(req_start_time),
      .req_end_time(req_end_time),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_bucket_index(rsp_bucket_index),
      .rsp_distinct_destinations(rsp_distinct_destinations),
      .rsp_incident_flows(rsp_incident_flows)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // incident table mirror
   bit          tbl_valid [NUM_ENTRIES];
   logic [55:0] tbl_key   [NUM_ENTRIES];
   logic [31:0] tbl_flows [NUM_ENTRIES];
   logic [63:0] tbl_pkts  [NUM_ENTRIES];
   logic [63:0] tbl_octs  [NUM_ENTRIES];
   logic [31:0] tbl_first [NUM_ENTRIES];
   logic [31:0] tbl_last  [NUM_ENTRIES];
   int          tbl_fill  [NUM_ENTRIES];
   logic [31:0] tbl_dests [NUM_ENTRIES][DESTS_PER_ENTRY];

   flow_record_type     pending_records[$];
   incident_result_type expected_results[$];
   int  mismatches = 0;
   int  idle_cycles = 0;
   bit  stimulus_done = 1'b0;
   logic busy_at_edge = 1'b1;

   function automatic incident_result_type aggregate_record(flow_record_type r);
      incident_result_type res;
      logic [55:0] key;
      logic [15:0] hash;
      int bucket, base, hit, free_way, e;
      key = {r.src, r.port, r.proto};
      hash = r.src[15:0] ^ r.src[31:16] ^ r.port;
      bucket = int'(hash) & ((1 << BUCKET_BITS) - 1);
      base = bucket * WAYS;
      hit = -1;
      free_way = -1;
      for (int w = 0; w < WAYS; w++) begin
         if (tbl_valid[base + w]) begin
            if (hit < 0 && tbl_key[base + w] == key) hit = w;
         end else if (free_way < 0) begin
            free_way = w;
         end
      end
      res.bucket = bucket[BUCKET_OUT_W-1:0];
      if (hit >= 0) begin
         e = base + hit;
         tbl_flows[e] += 1;
         tbl_pkts[e] += {32'd0, r.pkts};
         tbl_octs[e] += {32'd0, r.octs};
         if (tbl_first[e] > r.t_first) tbl_first[e] = r.t_first;
         if (tbl_last[e] < r.t_last) tbl_last[e] = r.t_last;
         res.flows = tbl_flows[e];
         res.dests = tbl_fill[e][DESTS_OUT_W-1:0];
         res.status = ST_NEW_DEST;
         for (int d = 0; d < tbl_fill[e]; d++)
            if (tbl_dests[e][d] == r.dst) res.status = ST_DEST_KNOWN;
         if (res.status == ST_NEW_DEST) begin
            if (tbl_fill[e] >= DESTS_PER_ENTRY) begin
               res.status = ST_DEST_FULL;
            end else begin
               tbl_dests[e][tbl_fill[e]] = r.dst;
               tbl_fill[e] += 1;
               res.dests = tbl_fill[e][DESTS_OUT_W-1:0];
            end
         end
      end else if (free_way < 0) begin
         res.status = ST_BUCKET_FULL;
         res.dests = '0;
         res.flows = '0;
      end else begin
         e = base + free_way;
         tbl_valid[e] = 1'b1;
         tbl_key[e] = key;
         tbl_flows[e] = 32'd1;
         tbl_pkts[e] = {32'd0, r.pkts};
         tbl_octs[e] = {32'd0, r.octs};
         tbl_first[e] = r.t_first;
         tbl_last[e] = r.t_last;
         tbl_fill[e] = 1;
         tbl_dests[e][0] = r.dst;
         res.status = ST_NEW_INCIDENT;
         res.dests = DESTS_OUT_W'(1);
         res.flows = FLOWS_W'(1);
      end
      return res;
   endfunction

   function automatic int random_gap();
      if ($urandom_range(0, 3) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
      return $urandom_range(0, 3);
   endfunction

   // driver
   int gap_left = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (start && !busy_at_edge) begin
            start <= 1'b0;
            gap_left <= random_gap();
         end else if (!start) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
            end else if (pending_records.size() > 0) begin
               flow_record_type r;
               r = pending_records.pop_front();
               req_source_address      <= r.src;
               req_destination_port    <= r.port;
               req_protocol_number     <= r.proto;
               req_destination_address <= r.dst;
               req_packet_count        <= r.pkts;
               req_octet_count         <= r.octs;
               req_start_time          <= r.t_first;
               req_end_time            <= r.t_last;
               start <= 1'b1;
               expected_results.push_back(aggregate_record(r));
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      busy_at_edge <= busy;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((start && !busy) || rsp_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result transaction: status %0d bucket %0d",
                           rsp_status, rsp_bucket_index);
            end else begin
               incident_result_type exp_r;
               exp_r = expected_results.pop_front();
               if (rsp_status !== exp_r.status || rsp_bucket_index !== exp_r.bucket ||
                   rsp_distinct_destinations !== exp_r.dests ||
                   rsp_incident_flows !== exp_r.flows) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp st %0d bk %0d ds %0d fl %0d, got st %0d bk %0d ds %0d fl %0d",
                              exp_r.status, exp_r.bucket, exp_r.dests, exp_r.flows,
                              rsp_status, rsp_bucket_index, rsp_distinct_destinations,
                              rsp_incident_flows);
               end
            end
         end
      end
   end

   function automatic flow_record_type make_record(logic [31:0] src, logic [15:0] port,
                                                   logic [7:0] proto, logic [31:0] dst);
      flow_record_type r;
      r.src = src;
      r.port = port;
      r.proto = proto;
      r.dst = dst;
      r.pkts = $urandom();
      r.octs = $urandom();
      r.t_first = $urandom();
      r.t_last = $urandom();
      return r;
   endfunction

   initial begin
      flow_record_type r;
      logic [31:0] srcs [8];
      logic [15:0] ports [8];
      logic [7:0]  protos [8];
      int k;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, sums past 32 bits, time extremes
      r = make_record('1, '1, '1, '1);
      r.pkts = '1; r.octs = '1; r.t_first = '1; r.t_last = '0;
      pending_records.push_back(r);
      r.t_first = '0; r.t_last = '1;
      pending_records.push_back(r);
      pending_records.push_back(r);
      r = make_record('0, '0, '0, '0);
      r.pkts = '0; r.octs = '0;
      pending_records.push_back(r);
      // fill one destination set past its capacity
      for (int i = 0; i < DESTS_PER_ENTRY + 2; i++)
         pending_records.push_back(make_record(32'h0A000001, 16'd80, 8'd6, 32'hC0A80000 + i));
      pending_records.push_back(make_record(32'h0A000001, 16'd80, 8'd6, 32'hC0A80003));
      // same bucket, different keys: fill the bucket and overflow it
      for (int i = 0; i < WAYS + 2; i++)
         pending_records.push_back(make_record(32'h00010001 * (i + 1), 16'd0, 8'd17, 32'h1));
      pending_records.push_back(make_record(32'h00010001, 16'd0, 8'd17, 32'h2));

      // random: a small pool of keys in few buckets, with noise records
      for (int i = 0; i < 8; i++) begin
         srcs[i] = $urandom();
         ports[i] = 16'($urandom());
         protos[i] = 8'($urandom());
      end
      for (int i = 0; i < 1030; i++) begin
         if (i % 150 == 0) begin
            k = $urandom_range(0, 7);
            srcs[k] = $urandom();
            ports[k] = 16'($urandom());
            protos[k] = 8'($urandom());
         end
         case ($urandom_range(0, 9))
            0: r = make_record($urandom(), 16'($urandom()), 8'($urandom()), $urandom());
            1, 2: begin
               // same fold, different key to collide in a bucket
               k = $urandom_range(0, 7);
               r = make_record(srcs[k] ^ {16'($urandom_range(0, 3)), 16'd0}, ports[k],
                               protos[k], $urandom_range(0, 15));
               r.src[15:0] = srcs[k][15:0] ^ r.src[31:16] ^ srcs[k][31:16];
            end
            default: begin
               k = $urandom_range(0, 7);
               r = make_record(srcs[k], ports[k], protos[k], $urandom_range(0, 11));
            end
         endcase
         pending_records.push_back(r);
      end

      wait (pending_records.size() == 0 && !start);
      wait (expected_results.size() == 0);
      repeat (2 * WAYS + 2 * DESTS_PER_ENTRY + 10) @(posedge clock);
      stimulus_done = 1'b1;
      if (mismatches == 0 && expected_results.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      wait (idle_cycles >= IDLE_LIMIT && !stimulus_done);
      $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire
